### rtl/ectp_pkg.sv
// shared types and constants for the event count time profiler
`default_nettype none
package ectp_pkg;
    localparam int NUM_W   = 10;
    localparam int COUNT_W = 32;
    localparam int TIME_W  = 64;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;

    typedef enum logic [0:0] {
        ACT_CALL   = 1'b0,
        ACT_REPORT = 1'b1
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_ENTRY_UPD,
        ST_EXIT_UPD,
        ST_SORT_INIT,
        ST_SORT_RD,
        ST_SORT_WAIT,
        ST_SORT_CMP,
        ST_EMIT_RD,
        ST_EMIT_WAIT,
        ST_EMIT_OUT,
        ST_EMPTY_OUT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic latch_in;
        logic scan_clr;
        logic scan_rd;
        logic scan_step;
        logic entry_upd;
        logic exit_upd;
        logic sort_init;
        logic sort_rd;
        logic sort_cmp;
        logic emit_rd;
        logic emit_load;
        logic empty_load;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic is_report;
        logic inside_call;
        logic scan_done;
        logic scan_hit;
        logic table_empty;
        logic sort_done;
        logic emit_done;
        logic out_full;
    } stat_t;
endpackage
`default_nettype wire

### rtl/ectp_in_if.sv
// input channel interface
`default_nettype none
interface ectp_in_if;
    import ectp_pkg::*;
    logic              valid;
    logic              ready;
    logic              action;
    logic [NUM_W-1:0]  call_number;
    logic [TIME_W-1:0] timestamp_ns;
    modport source (output valid, action, call_number, timestamp_ns, input ready);
    modport sink (input valid, action, call_number, timestamp_ns, output ready);
endinterface
`default_nettype wire

### rtl/ectp_out_if.sv
// result channel interface
`default_nettype none
interface ectp_out_if;
    import ectp_pkg::*;
    logic               valid;
    logic               ready;
    logic [NUM_W-1:0]   entry_number;
    logic [COUNT_W-1:0] call_count;
    logic [TIME_W-1:0]  total_ns;
    logic               empty_table;
    logic               last;
    modport source (output valid, entry_number, call_count, total_ns, empty_table, last,
                    input ready);
    modport sink (input valid, entry_number, call_count, total_ns, empty_table, last,
                  output ready);
endinterface
`default_nettype wire

### rtl/ectp_ctrl.sv
// controller state machine for the profiler
`default_nettype none
module ectp_ctrl
    import ectp_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire stat_t stat,
    output ctrl_t      ctrl
);
    state_t state_reg, state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (in_valid) state_next = ST_SCAN;
            ST_SCAN:
            begin
                if (stat.is_report)
                    state_next = stat.table_empty ? ST_EMPTY_OUT : ST_SORT_INIT;
                else if (stat.scan_done)
                    state_next = stat.inside_call ? ST_EXIT_UPD : ST_ENTRY_UPD;
                else
                    state_next = ST_SCAN_WAIT;
            end
            ST_SCAN_WAIT:
            begin
                if (stat.scan_hit)
                    state_next = stat.inside_call ? ST_EXIT_UPD : ST_ENTRY_UPD;
                else
                    state_next = ST_SCAN;
            end
            ST_ENTRY_UPD: state_next = ST_IDLE;
            ST_EXIT_UPD:  state_next = ST_IDLE;
            ST_SORT_INIT: state_next = ST_SORT_RD;
            ST_SORT_RD:   state_next = ST_SORT_WAIT;
            ST_SORT_WAIT: state_next = ST_SORT_CMP;
            ST_SORT_CMP:  state_next = stat.sort_done ? ST_EMIT_RD : ST_SORT_RD;
            ST_EMIT_RD:   state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT: if (!stat.out_full) state_next = ST_EMIT_OUT;
            ST_EMIT_OUT:  state_next = stat.emit_done ? ST_IDLE : ST_SORT_INIT;
            ST_EMPTY_OUT: if (!stat.out_full) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctrl = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                ctrl.latch_in = in_valid;
                ctrl.scan_clr = in_valid;
            end
            ST_SCAN:      ctrl.scan_rd = !stat.is_report && !stat.scan_done;
            ST_SCAN_WAIT: ctrl.scan_step = !stat.scan_hit;
            ST_ENTRY_UPD: ctrl.entry_upd = 1'b1;
            ST_EXIT_UPD:  ctrl.exit_upd = 1'b1;
            ST_SORT_INIT: ctrl.sort_init = 1'b1;
            ST_SORT_RD:   ctrl.sort_rd = 1'b1;
            ST_SORT_CMP:  ctrl.sort_cmp = 1'b1;
            ST_EMIT_RD:   ctrl.emit_rd = 1'b1;
            ST_EMIT_OUT:  ctrl.emit_load = 1'b1;
            ST_EMPTY_OUT: ctrl.empty_load = !stat.out_full;
            default:      ctrl = '0;
        endcase
    end
endmodule
`default_nettype wire

### rtl/ectp_datapath.sv
// table storage, search, selection sort and output register
`default_nettype none
module ectp_datapath
    import ectp_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire ctrl_t        ctrl,
    input  wire logic         rdy,
    output stat_t             stat,
    ectp_in_if.sink           in_ch,
    ectp_out_if.source        out_ch
);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

    // table memories
    logic [NUM_W-1:0]   num_mem   [TABLE_DEPTH];
    logic [COUNT_W-1:0] count_mem [TABLE_DEPTH];
    logic [TIME_W-1:0]  time_mem  [TABLE_DEPTH];
    // emitted flags, one per slot
    logic [TABLE_DEPTH-1:0] done_reg;

    logic [CNT_W-1:0]   used_reg;
    logic               inside_reg;
    logic [NUM_W-1:0]   cur_num_reg;
    logic [TIME_W-1:0]  stamp_reg;
    logic               act_reg;
    logic [NUM_W-1:0]   in_num_reg;
    logic [TIME_W-1:0]  in_ts_reg;

    logic [CNT_W-1:0]   idx_reg;
    logic               hit_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic [NUM_W-1:0]   rd_num_reg;
    logic [COUNT_W-1:0] rd_count_reg;
    logic [TIME_W-1:0]  rd_time_reg;
    logic               rd_en;

    logic               best_vld_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [COUNT_W-1:0] best_cnt_reg;
    logic [CNT_W-1:0]   emitted_reg;

    logic               ov_reg;
    logic [NUM_W-1:0]   o_num_reg;
    logic [COUNT_W-1:0] o_cnt_reg;
    logic [TIME_W-1:0]  o_time_reg;
    logic               o_empty_reg;
    logic               o_last_reg;

    logic [IDX_W-1:0]   wr_addr;
    logic [TIME_W-1:0]  elapsed;
    logic [TIME_W:0]    tsum;

    // slot address: scan/sort walk index, or selected best during emit
    always_comb
    begin
        if (ctrl.emit_rd)
            rd_addr = best_idx_reg;
        else
            rd_addr = idx_reg[IDX_W-1:0];
        rd_en = ctrl.scan_rd || ctrl.sort_rd || ctrl.emit_rd;
        wr_addr = hit_reg ? idx_reg[IDX_W-1:0] : used_reg[IDX_W-1:0];
        elapsed = (in_ts_reg >= stamp_reg) ? in_ts_reg - stamp_reg : '0;
        tsum = {1'b0, rd_time_reg} + {1'b0, elapsed};
    end

    // memory read and write ports
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_num_reg   <= num_mem[rd_addr];
            rd_count_reg <= count_mem[rd_addr];
            rd_time_reg  <= time_mem[rd_addr];
        end
        if (ctrl.entry_upd && (hit_reg || used_reg != DEPTH_C))
        begin
            num_mem[wr_addr] <= in_num_reg;
            if (!hit_reg)
            begin
                count_mem[wr_addr] <= COUNT_W'(1);
                time_mem[wr_addr]  <= '0;
            end
            else if (rd_count_reg != COUNT_MAX)
                count_mem[wr_addr] <= rd_count_reg + COUNT_W'(1);
        end
        if (ctrl.exit_upd && hit_reg)
            time_mem[idx_reg[IDX_W-1:0]] <= tsum[TIME_W] ? TIME_MAX : tsum[TIME_W-1:0];
    end

    // control state and walk registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            inside_reg   <= 1'b0;
            cur_num_reg  <= '0;
            stamp_reg    <= '0;
            idx_reg      <= '0;
            hit_reg      <= 1'b0;
            best_vld_reg <= 1'b0;
            best_idx_reg <= '0;
            best_cnt_reg <= '0;
            emitted_reg  <= '0;
            done_reg     <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            if (ctrl.scan_clr)
            begin
                idx_reg     <= '0;
                hit_reg     <= 1'b0;
                emitted_reg <= '0;
                done_reg    <= '0;
            end
            if (ctrl.scan_rd)
                hit_reg <= 1'b0;
            if (ctrl.scan_step)
                idx_reg <= idx_reg + CNT_W'(1);
            // compare read slot against searched number, only while a slot is under test
            if (stat.scan_hit && !stat.scan_done && !ctrl.scan_step && !ctrl.scan_rd
                && !ctrl.scan_clr && !hit_reg)
                hit_reg <= 1'b1;
            if (ctrl.entry_upd)
            begin
                if (!hit_reg && used_reg != DEPTH_C)
                    used_reg <= used_reg + CNT_W'(1);
                cur_num_reg <= in_num_reg;
                stamp_reg   <= in_ts_reg;
                inside_reg  <= 1'b1;
            end
            if (ctrl.exit_upd)
                inside_reg <= 1'b0;
            if (ctrl.sort_init)
            begin
                idx_reg      <= '0;
                best_vld_reg <= 1'b0;
            end
            if (ctrl.sort_rd)
                idx_reg <= idx_reg;
            if (ctrl.sort_cmp)
            begin
                if (!done_reg[idx_reg[IDX_W-1:0]]
                    && (!best_vld_reg || rd_count_reg > best_cnt_reg))
                begin
                    best_vld_reg <= 1'b1;
                    best_idx_reg <= idx_reg[IDX_W-1:0];
                    best_cnt_reg <= rd_count_reg;
                end
                idx_reg <= idx_reg + CNT_W'(1);
            end
            if (ctrl.emit_load)
            begin
                done_reg[best_idx_reg] <= 1'b1;
                emitted_reg <= emitted_reg + CNT_W'(1);
            end
            if (ctrl.emit_load || ctrl.empty_load)
                ov_reg <= 1'b1;
            else if (out_ch.ready)
                ov_reg <= 1'b0;
        end
    end

    // input and output payload registers
    always_ff @(posedge clk)
    begin
        if (ctrl.latch_in)
        begin
            act_reg    <= in_ch.action;
            in_num_reg <= in_ch.call_number;
            in_ts_reg  <= in_ch.timestamp_ns;
        end
        if (ctrl.emit_load)
        begin
            o_num_reg   <= rd_num_reg;
            o_cnt_reg   <= rd_count_reg;
            o_time_reg  <= rd_time_reg;
            o_empty_reg <= 1'b0;
            o_last_reg  <= (emitted_reg + CNT_W'(1)) == used_reg;
        end
        else if (ctrl.empty_load)
        begin
            o_num_reg   <= '0;
            o_cnt_reg   <= '0;
            o_time_reg  <= '0;
            o_empty_reg <= 1'b1;
            o_last_reg  <= 1'b1;
        end
    end

    // status
    always_comb
    begin
        stat.is_report   = (act_reg == ACT_REPORT);
        stat.inside_call = inside_reg;
        stat.scan_done   = (idx_reg == used_reg);
        stat.scan_hit    = hit_reg ||
                           (rd_num_reg == (inside_reg ? cur_num_reg : in_num_reg));
        stat.table_empty = (used_reg == '0);
        stat.sort_done   = (idx_reg + CNT_W'(1)) == used_reg;
        stat.emit_done   = (emitted_reg + CNT_W'(1)) == used_reg;
        stat.out_full    = ov_reg && !out_ch.ready;
        in_ch.ready      = rdy;
    end

    assign out_ch.valid        = ov_reg;
    assign out_ch.entry_number = o_num_reg;
    assign out_ch.call_count   = o_cnt_reg;
    assign out_ch.total_ns     = o_time_reg;
    assign out_ch.empty_table  = o_empty_reg;
    assign out_ch.last         = o_last_reg;
endmodule
`default_nettype wire

### rtl/event_count_time_profiler.sv
// Usage: one input channel in_ch carries call events (action 0) and
// report requests (action 1); one result channel out_ch carries report rows.
// A call event alternates entry and exit. Entry searches the table one slot
// at a time and then counts the call, inserting new numbers while room
// remains. Exit adds elapsed nanoseconds to the current call's slot.
// For a call event, the search loop through the single table read port
// walks the used slots, stopping at a hit, before the next acceptance.
// A report does a selection pass over the used slots for each row, all
// through the same read port.
// in_ch.ready is high only between items; one item is worked at a time.
// Rows leave through an output register; when the receiver stalls the row
// is held and the next row of a report waits for it. After the final row
// is loaded the block goes idle and takes a new transaction while it waits.
// Reset clears the slot count, call state and output valid; the table
// contents need no clearing since only allocated slots are ever read.
`default_nettype none
module event_count_time_profiler
    import ectp_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ectp_in_if.sink    in_ch,
    ectp_out_if.source out_ch
);
    ctrl_t ctrl;
    stat_t stat;
    logic  rdy;

    ectp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (rdy),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    ectp_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .rdy    (rdy),
        .stat   (stat),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );
endmodule
`default_nettype wire
